// ===== design/tga_rle_pixel_decoder_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define TRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tga_rle_pkg.sv =====
package tga_rle_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED  = 1'b1;

  localparam logic [2:0] PB_RESET  = 3'd3;
  localparam logic       CMP_RESET = 1'b1;
  localparam logic [2:0] PB_MIN    = 3'd2;
  localparam logic [2:0] PB_MAX    = 3'd4;

  // floor(x / 3) == (x * 171) >> 9 for x < 256
  localparam logic [15:0] DIV3_MUL   = 16'd171;
  localparam int          DIV3_SHIFT = 9;

  typedef struct packed {
    logic        emit;
    logic [23:0] pix;
    logic        is16;
    logic [7:0]  repeat_cnt;
  } pix_evt_t;

  typedef struct packed {
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
    logic [5:0] grey;
    logic [7:0] repeat_cnt;
  } res_t;

  // Out-of-range sizes clamp to the nearest legal one.
  function automatic logic [2:0] eff_size(input logic [2:0] pb);
    logic [2:0] sz;
    if (pb < PB_MIN) begin
      sz = PB_MIN;
    end else if (pb > PB_MAX) begin
      sz = PB_MAX;
    end else begin
      sz = pb;
    end
    return sz;
  endfunction

endpackage

// ===== design/tga_rle_pixel_decoder.sv =====
// Targa pixel-data decoder. Takes the image's pixel bytes one per transfer on
// the in_ channel and returns one result per complete pixel on the out_
// channel: 6-bit red, green, blue, their truncated average (grey) and a repeat
// count. With compressed = 1 the bytes are run-length packets (header bit 7 set
// = run of (header & 0x7f)+1 copies of one pixel, clear = that many literal
// pixels); a run comes out once with its full count, never expanded. With
// compressed = 0 each pixel is literal and repeat_res is 1. pixel_bytes picks
// 16-bit 5:5:5 (2), 24-bit BGR (3) or 32-bit BGRA (4, alpha dropped); other
// codes clamp to 2 or 4. in_start_of_image on a byte clears the packet and
// pixel state before that byte is parsed. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user writes it only while the block is idle,
// which the block itself does not enforce. Rate: one byte per clock while
// in_ready is high. The parser, pixel assembly and color conversion are
// combinational between the parser state registers and the output register; a
// two-entry output stage (output register plus skid register) keeps in_ready
// high while one result waits; in_ready drops only when both entries are full.
module tga_rle_pixel_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_start_of_image,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [5:0]                         out_red,
  output logic [5:0]                         out_green,
  output logic [5:0]                         out_blue,
  output logic [5:0]                         out_grey,
  output logic [7:0]                         out_repeat_res,
  input  logic                               cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]            pixel_bytes_r;
  logic                  compressed_r;
  logic                  accept;
  tga_rle_pkg::pix_evt_t evt;
  tga_rle_pkg::res_t     res, res_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= tga_rle_pkg::PB_RESET;
      compressed_r  <= tga_rle_pkg::CMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tga_rle_pkg::CFG_PIXEL_BYTES: pixel_bytes_r <= cfg_data;
        tga_rle_pkg::CFG_COMPRESSED:  compressed_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid & in_ready;

  // packet and pixel state machine; evt is the pixel finished by this byte
  tga_rle_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .start_of_image (in_start_of_image),
    .pixel_bytes    (pixel_bytes_r),
    .compressed     (compressed_r),
    .evt            (evt)
  );

  // channel extraction and grey average
  tga_rle_color u_color (
    .evt (evt),
    .res (res)
  );

  // output register with skid entry
  tga_rle_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept & evt.emit),
    .res_in    (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_red        = res_out.red;
  assign out_green      = res_out.green;
  assign out_blue       = res_out.blue;
  assign out_grey       = res_out.grey;
  assign out_repeat_res = res_out.repeat_cnt;

endmodule

// ===== design/tga_rle_parser.sv =====
module tga_rle_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  start_of_image,
  input  logic [2:0]            pixel_bytes,
  input  logic                  compressed,
  output tga_rle_pkg::pix_evt_t evt
);

  logic        phase_r, phase_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] asm_r, asm_nxt;

  logic        phase_c, run_c;
  logic [7:0]  left_c;
  logic [1:0]  bip_c;
  logic [23:0] asm_c, asm_m;
  logic [2:0]  sz;
  logic        complete;

  always_comb begin
    // start of image clears the parser before this byte
    phase_c = start_of_image ? 1'b0  : phase_r;
    run_c   = start_of_image ? 1'b0  : run_r;
    left_c  = start_of_image ? 8'd0  : left_r;
    bip_c   = start_of_image ? 2'd0  : bip_r;
    asm_c   = start_of_image ? 24'd0 : asm_r;

    sz = tga_rle_pkg::eff_size(pixel_bytes);

    case (bip_c)
      2'd0:    asm_m = asm_c | {16'd0, data_byte};
      2'd1:    asm_m = asm_c | {8'd0, data_byte, 8'd0};
      2'd2:    asm_m = asm_c | {data_byte, 16'd0};
      default: asm_m = asm_c;  // alpha byte
    endcase

    complete = ({1'b0, bip_c} + 3'd1) >= sz;

    phase_nxt = phase_c;
    run_nxt   = run_c;
    left_nxt  = left_c;
    bip_nxt   = bip_c + 2'd1;
    asm_nxt   = asm_m;

    evt.emit       = 1'b0;
    evt.pix        = asm_m;
    evt.is16       = (sz == tga_rle_pkg::PB_MIN);
    evt.repeat_cnt = 8'd1;

    if (!compressed) begin
      if (complete) begin
        evt.emit = 1'b1;
        bip_nxt  = 2'd0;
        asm_nxt  = 24'd0;
      end
    end else if (!phase_c) begin
      // packet header
      run_nxt   = data_byte[7];
      left_nxt  = {1'b0, data_byte[6:0]} + 8'd1;
      phase_nxt = 1'b1;
      bip_nxt   = 2'd0;
      asm_nxt   = 24'd0;
    end else if (complete) begin
      evt.emit = 1'b1;
      bip_nxt  = 2'd0;
      asm_nxt  = 24'd0;
      if (run_c) begin
        evt.repeat_cnt = left_c;
        left_nxt       = 8'd0;
        phase_nxt      = 1'b0;
      end else begin
        left_nxt = left_c - 8'd1;
        if (left_c == 8'd1) begin
          phase_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      run_r   <= 1'b0;
      left_r  <= 8'd0;
      bip_r   <= 2'd0;
      asm_r   <= 24'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      left_r  <= left_nxt;
      bip_r   <= bip_nxt;
      asm_r   <= asm_nxt;
    end
  end

endmodule

// ===== design/tga_rle_color.sv =====
module tga_rle_color (
  input  tga_rle_pkg::pix_evt_t evt,
  output tga_rle_pkg::res_t     res
);

  logic [5:0]  r, g, b;
  logic [7:0]  sum;
  logic [15:0] prod;

  always_comb begin
    if (evt.is16) begin
      // little-endian 5:5:5, top bit ignored
      r = {evt.pix[14:10], 1'b0};
      g = {evt.pix[9:5], 1'b0};
      b = {evt.pix[4:0], 1'b0};
    end else begin
      b = evt.pix[7:2];
      g = evt.pix[15:10];
      r = evt.pix[23:18];
    end
    sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
    prod = {8'd0, sum} * tga_rle_pkg::DIV3_MUL;

    res.red        = r;
    res.green      = g;
    res.blue       = b;
    res.grey       = prod[tga_rle_pkg::DIV3_SHIFT +: 6];
    res.repeat_cnt = evt.repeat_cnt;
  end

endmodule

// ===== design/tga_rle_out_buf.sv =====
module tga_rle_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tga_rle_pkg::res_t res_in,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_rle_pkg::res_t res_out
);

  logic              out_valid_r, skid_valid_r;
  tga_rle_pkg::res_t out_r, skid_r;
  logic              out_fire;

  assign out_fire  = out_valid_r & out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign res_out   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (load) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (load) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res_in;
      end else begin
        out_r <= res_in;
      end
    end
  end

endmodule

// ===== design/tga_rle_checker.sv =====
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_red,
  input logic [5:0] out_green,
  input logic [5:0] out_blue,
  input logic [5:0] out_grey,
  input logic [7:0] out_repeat_res
);

  // a stalled result stays valid with its repeat count and grey unchanged
  `TRD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_repeat_res) && $stable(out_grey), "result changed while stalled")

  // no result right after reset
  `TRD_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid, "out_valid set after reset")

  // repeat count stays within one packet
  `TRD_ASSERT(a_repeat_rng, clk, rst_n, out_valid |-> out_repeat_res != 8'd0 && out_repeat_res <= 8'd128, "repeat count out of range")

  // grey is the truncated average
  `TRD_ASSERT(a_grey_avg, clk, rst_n, out_valid |-> 8'(out_grey) * 8'd3 <= 8'(out_red) + 8'(out_green) + 8'(out_blue) && 8'(out_grey) * 8'd3 + 8'd3 > 8'(out_red) + 8'(out_green) + 8'(out_blue), "grey is not the channel average")

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (.*);

// ===== tb/sv/tga_rle_pixel_decoder_checker.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_start_of_image,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [5:0]                         out_red,
  input  logic [5:0]                         out_green,
  input  logic [5:0]                         out_blue,
  input  logic [5:0]                         out_grey,
  input  logic [7:0]                         out_repeat_res,
  input  logic                               cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 result_count
);

  // Shadow configuration and parser state.
  logic [2:0]  pb_q;
  logic        cmp_q;
  logic        in_data_phase;
  logic        run_pkt;
  logic [7:0]  px_left;
  logic [1:0]  byte_idx;
  logic [23:0] asm_q;

  tga_rle_pkg::res_t pending_colors[$];
  int   errors  = 0;
  int   checked = 0;

  function automatic int pix_size(input logic [2:0] pb);
    if (pb < 3'd2) return 2;
    if (pb > 3'd4) return 4;
    return int'(pb);
  endfunction

  // Adds one byte to the pixel under assembly; 1 when the pixel is complete.
  function automatic bit take_byte(input logic [7:0] b);
    int sz;
    sz = pix_size(pb_q);
    if (byte_idx < 2'd3) asm_q = asm_q | (24'(b) << (8 * byte_idx));
    if (int'(byte_idx) + 1 >= sz) return 1'b1;
    byte_idx = byte_idx + 2'd1;
    return 1'b0;
  endfunction

  task automatic convert_pixel(input logic [7:0] rep);
    logic [5:0]        r, g, bl;
    int                sum;
    tga_rle_pkg::res_t e;
    if (pix_size(pb_q) == 2) begin
      // 5:5:5 word, bit 15 ignored, each channel widened to six bits
      r  = {asm_q[14:10], 1'b0};
      g  = {asm_q[9:5], 1'b0};
      bl = {asm_q[4:0], 1'b0};
    end else begin
      bl = asm_q[7:2];
      g  = asm_q[15:10];
      r  = asm_q[23:18];
    end
    sum          = r + g + bl;
    e.red        = r;
    e.green      = g;
    e.blue       = bl;
    e.grey       = 6'(sum / 3);
    e.repeat_cnt = rep;
    pending_colors.push_back(e);
    byte_idx = 2'd0;
    asm_q    = 24'd0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    if (sof) begin
      in_data_phase = 1'b0;
      run_pkt       = 1'b0;
      px_left       = 8'd0;
      byte_idx      = 2'd0;
      asm_q         = 24'd0;
    end
    if (!cmp_q) begin
      if (take_byte(b)) convert_pixel(8'd1);
    end else if (!in_data_phase) begin
      run_pkt       = b[7];
      px_left       = {1'b0, b[6:0]} + 8'd1;
      in_data_phase = 1'b1;
      byte_idx      = 2'd0;
      asm_q         = 24'd0;
    end else if (take_byte(b)) begin
      if (run_pkt) begin
        convert_pixel(px_left);
        px_left       = 8'd0;
        in_data_phase = 1'b0;
      end else begin
        convert_pixel(8'd1);
        px_left = px_left - 8'd1;
        if (px_left == 8'd0) in_data_phase = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    tga_rle_pkg::res_t e;
    if (!rst_n) begin
      pb_q          = tga_rle_pkg::PB_RESET;
      cmp_q         = tga_rle_pkg::CMP_RESET;
      in_data_phase = 1'b0;
      run_pkt       = 1'b0;
      px_left       = 8'd0;
      byte_idx      = 2'd0;
      asm_q         = 24'd0;
      pending_colors.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == tga_rle_pkg::CFG_PIXEL_BYTES) pb_q = cfg_data[2:0];
        else if (cfg_index == tga_rle_pkg::CFG_COMPRESSED) cmp_q = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        checked++;
        if (pending_colors.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d grey=%0d rep=%0d", $realtime,
                     out_red, out_green, out_blue, out_grey, out_repeat_res);
          errors++;
        end else begin
          e = pending_colors.pop_front();
          if (out_red != e.red || out_green != e.green || out_blue != e.blue ||
              out_grey != e.grey || out_repeat_res != e.repeat_cnt) begin
            if (errors < 10) begin
              $display("%0t: result mismatch, expected r=%0d g=%0d b=%0d grey=%0d rep=%0d",
                       $realtime, e.red, e.green, e.blue, e.grey, e.repeat_cnt);
              $display("%0t:                  actual r=%0d g=%0d b=%0d grey=%0d rep=%0d",
                       $realtime, out_red, out_green, out_blue, out_grey, out_repeat_res);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_data_byte, in_start_of_image);
    end
    fail_count   <= errors;
    pending      <= pending_colors.size();
    result_count <= checked;
  end

endmodule

// ===== tb/sv/tga_rle_pixel_decoder_test.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_test;

  // Random part length and run-time bounds, in bytes and clock cycles.
  localparam int RANDOM_BYTES = 750;
  localparam int HOLD_CYCLES  = 80;    // long receiver stall for back-pressure
  localparam int DRAIN_CYCLES = 4;     // headers give no result
  localparam int TAIL_CYCLES  = 10;
  localparam int LIMIT_CYCLES = 300000;

  logic                               clk               = 1'b0;
  logic                               rst_n             = 1'b0;
  logic                               in_valid          = 1'b0;
  logic                               in_ready;
  logic [7:0]                         in_data_byte      = 8'd0;
  logic                               in_start_of_image = 1'b0;
  logic                               out_valid;
  logic                               out_ready         = 1'b0;
  logic [5:0]                         out_red;
  logic [5:0]                         out_green;
  logic [5:0]                         out_blue;
  logic [5:0]                         out_grey;
  logic [7:0]                         out_repeat_res;
  logic                               cfg_we            = 1'b0;
  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index         = tga_rle_pkg::CFG_PIXEL_BYTES;
  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data          = '0;

  int fail_count;
  int pending;
  int result_count;

  // Shared between sender and receiver; written with nonblocking assignments.
  logic idle_on     = 1'b1;  // random gaps on both sides during this phase
  int   holds_asked = 0;     // receiver long stalls requested by the stimulus

  int bytes_sent = 0;
  int settings   = 0;
  int cur_size   = 3;        // effective bytes per pixel, for packet building

  tga_rle_pixel_decoder i_dut (.*);

  tga_rle_pixel_decoder_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly random bytes, with a bias toward the all-zero and all-one values.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // One byte transfer on the input channel, after an optional idle gap.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_start_of_image <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop the input, let every expected result drain, then write both registers.
  task automatic set_mode(input logic [2:0] pb, input logic cmp);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tga_rle_pkg::CFG_PIXEL_BYTES;
    cfg_data  <= pb;
    @(posedge clk);
    cfg_index <= tga_rle_pkg::CFG_COMPRESSED;
    cfg_data  <= {2'b00, cmp};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_size = (pb < 3'd2) ? 2 : (pb > 3'd4) ? 4 : int'(pb);
    settings++;
  endtask

  // Well-formed run-length packet: header, then one pixel (run) or N pixels (raw).
  task automatic send_packet(input logic sof);
    logic [7:0] hdr;
    int         npix;
    hdr[7] = 1'($urandom_range(0, 1));
    // Long counts are cheap for runs, expensive for raw packets.
    if ((hdr[7] && $urandom_range(0, 3) == 0) || $urandom_range(0, 39) == 0)
      hdr[6:0] = 7'($urandom_range(0, 127));
    else
      hdr[6:0] = 7'($urandom_range(0, 7));
    npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
    send_byte(hdr, sof);
    repeat (npix * cur_size) send_byte(pick_byte(), 1'b0);
  endtask

  // Receiver: random stall per transfer, plus a long hold-off when asked.
  initial begin : receiver
    int gap;
    int holds_done;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_asked > holds_done) begin
        gap = HOLD_CYCLES;
        holds_done++;
      end else begin
        gap = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         phase;
    int         target;
    logic [2:0] pb;
    logic       cmp;
    logic       resync;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset mode is 24-bit run-length packets.
    // Run of one, all-zero pixel, header marks start of image.
    send_byte(8'h80, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    // Longest run, all-one pixel.
    send_byte(8'hff, 1'b0);
    repeat (3) send_byte(8'hff, 1'b0);
    // Raw packet of one pixel.
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);

    // Size code below range acts as 16-bit; top bit of the word is ignored.
    set_mode(3'd0, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);

    // Size code above range acts as 32-bit, uncompressed; alpha dropped.
    set_mode(3'd7, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hfe, 1'b0);
    // Three bytes of a pixel, then shrink the size: next byte finishes it.
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h20, 1'b0);
    set_mode(3'd2, 1'b0);
    send_byte(8'h10, 1'b0);

    // Start of image in the middle of a pixel drops the partial packet.
    set_mode(3'd1, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);

    // Random phases: new settings each phase, mostly well-formed packets.
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      phase++;
      idle_on <= ($urandom_range(0, 3) != 0);
      pb  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
      cmp = ($urandom_range(0, 3) != 0);
      set_mode(pb, cmp);
      // Block fills and stalls its input while the receiver holds off.
      if (phase == 3 || phase == 8) holds_asked <= holds_asked + 1;
      resync = ($urandom_range(0, 3) != 0);
      for (int n = bytes_sent + $urandom_range(30, 90); bytes_sent < n; ) begin
        if (!cmp) begin
          send_byte(pick_byte(), $urandom_range(0, 19) == 0);
        end else if ($urandom_range(0, 9) == 0) begin
          // noise byte, possibly a fresh image; realign on the next packet
          send_byte(pick_byte(), 1'($urandom_range(0, 1)));
          resync = 1'b1;
        end else begin
          send_packet(resync);
          resync = 1'b0;
        end
      end
    end

    // Drain: everything expected has to arrive, then a short quiet tail.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes across %0d register settings and %0d random phases,",
             bytes_sent, settings, phase);
    $display("checked %0d pixel results, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0) begin
      $display("tga_rle_pixel_decoder test passed");
    end else begin
      $display("tga_rle_pixel_decoder test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("tga_rle_pixel_decoder test failed");
    $finish;
  end

endmodule
